### sv/bld_pkg.sv
// Shared types, constants and functions for the binary log deframer.
package bld_pkg;

   localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
   localparam logic [7:0]  SYNC_BYTE0     = 8'hAA;
   localparam logic [7:0]  SYNC_BYTE1     = 8'h44;
   localparam logic [7:0]  SYNC_BYTE2     = 8'h12;
   localparam logic [15:0] HDR_LEN        = 16'd28;
   localparam logic [15:0] MAX_BODY_RESET = 16'd4064;

   // header byte offsets
   localparam logic [15:0] HDR_ID_LO   = 16'd4;
   localparam logic [15:0] HDR_ID_HI   = 16'd5;
   localparam logic [15:0] HDR_LEN_LO  = 16'd8;
   localparam logic [15:0] HDR_LEN_HI  = 16'd9;
   localparam logic [15:0] HDR_WEEK_LO = 16'd14;
   localparam logic [15:0] HDR_WEEK_HI = 16'd15;
   localparam logic [15:0] HDR_MS_B0   = 16'd16;
   localparam logic [15:0] HDR_MS_B1   = 16'd17;
   localparam logic [15:0] HDR_MS_B2   = 16'd18;
   localparam logic [15:0] HDR_MS_B3   = 16'd19;

   // result kinds
   localparam logic [1:0] KIND_BODY     = 2'd0;
   localparam logic [1:0] KIND_CRC_GOOD = 2'd1;
   localparam logic [1:0] KIND_CRC_BAD  = 2'd2;
   localparam logic [1:0] KIND_DROPPED  = 2'd3;

   // message ids and classes
   localparam logic [15:0] ID_IONO  = 16'd8;
   localparam logic [15:0] ID_OBS   = 16'd43;
   localparam logic [15:0] ID_EPH   = 16'd7;
   localparam logic [15:0] ID_POS   = 16'd47;
   localparam logic [2:0]  CLASS_OTHER = 3'd0;
   localparam logic [2:0]  CLASS_IONO  = 3'd1;
   localparam logic [2:0]  CLASS_OBS   = 3'd2;
   localparam logic [2:0]  CLASS_EPH   = 3'd3;
   localparam logic [2:0]  CLASS_POS   = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2,
      PH_CRC  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  msg_class;
      logic [15:0] msg_id;
      logic [7:0]  body_byte;
      logic [15:0] body_index;
      logic [15:0] body_len;
      logic [15:0] week;
      logic [31:0] ms_of_week;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // reflected CRC-32, one byte, eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [2:0] class_of(input logic [15:0] id);
      logic [2:0] cls;
      case (id)
         ID_IONO: cls = CLASS_IONO;
         ID_OBS:  cls = CLASS_OBS;
         ID_EPH:  cls = CLASS_EPH;
         ID_POS:  cls = CLASS_POS;
         default: cls = CLASS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

### sv/bld_parser.sv
// Frame parser: sync hunt, header capture, length check, body pass-through and CRC check.
module bld_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic [15:0]         max_body_len,
   output bld_pkg::result_type result
);

   bld_pkg::phase_type phase_ff, phase_in;
   logic [15:0] sync_ff, sync_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] week_ff, week_in;
   logic [31:0] ms_ff, ms_in;
   logic [31:0] rxcrc_ff, rxcrc_in;

   logic [15:0] count_inc;
   logic [31:0] crc_upd;
   logic [31:0] rxcrc_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bld_pkg::PH_HUNT;
         sync_ff  <= '0;
         count_ff <= '0;
         crc_ff   <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         week_ff  <= '0;
         ms_ff    <= '0;
         rxcrc_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         sync_ff  <= sync_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         week_ff  <= week_in;
         ms_ff    <= ms_in;
         rxcrc_ff <= rxcrc_in;
      end
   end

   assign count_inc = count_ff + 16'd1;
   assign crc_upd   = bld_pkg::crc_byte(crc_ff, data_byte);

   always_comb begin
      case (count_ff[1:0])
         2'd0:    rxcrc_upd = rxcrc_ff | {24'd0, data_byte};
         2'd1:    rxcrc_upd = rxcrc_ff | {16'd0, data_byte, 8'd0};
         2'd2:    rxcrc_upd = rxcrc_ff | {8'd0, data_byte, 16'd0};
         default: rxcrc_upd = rxcrc_ff | {data_byte, 24'd0};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      sync_in  = sync_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      week_in  = week_ff;
      ms_in    = ms_ff;
      rxcrc_in = rxcrc_ff;

      result.valid           = 1'b0;
      result.data.kind       = bld_pkg::KIND_BODY;
      result.data.msg_class  = bld_pkg::class_of(id_ff);
      result.data.msg_id     = id_ff;
      result.data.body_byte  = '0;
      result.data.body_index = '0;
      result.data.body_len   = len_ff;
      result.data.week       = week_ff;
      result.data.ms_of_week = ms_ff;

      case (phase_ff)
         bld_pkg::PH_HUNT: begin
            if (sync_ff == {bld_pkg::SYNC_BYTE0, bld_pkg::SYNC_BYTE1}
                && data_byte == bld_pkg::SYNC_BYTE2) begin
               crc_in   = bld_pkg::crc_byte(bld_pkg::crc_byte(bld_pkg::crc_byte(
                             32'd0, bld_pkg::SYNC_BYTE0), bld_pkg::SYNC_BYTE1),
                             bld_pkg::SYNC_BYTE2);
               count_in = 16'd3;
               phase_in = bld_pkg::PH_HEAD;
            end else begin
               sync_in = {sync_ff[7:0], data_byte};
            end
         end

         bld_pkg::PH_HEAD: begin
            crc_in = crc_upd;
            case (count_ff)
               bld_pkg::HDR_ID_LO:   id_in   = {8'd0, data_byte};
               bld_pkg::HDR_ID_HI:   id_in   = {data_byte, id_ff[7:0]};
               bld_pkg::HDR_LEN_LO:  len_in  = {8'd0, data_byte};
               bld_pkg::HDR_LEN_HI:  len_in  = {data_byte, len_ff[7:0]};
               bld_pkg::HDR_WEEK_LO: week_in = {8'd0, data_byte};
               bld_pkg::HDR_WEEK_HI: week_in = {data_byte, week_ff[7:0]};
               bld_pkg::HDR_MS_B0:   ms_in   = {24'd0, data_byte};
               bld_pkg::HDR_MS_B1:   ms_in   = ms_ff | {16'd0, data_byte, 8'd0};
               bld_pkg::HDR_MS_B2:   ms_in   = ms_ff | {8'd0, data_byte, 16'd0};
               bld_pkg::HDR_MS_B3:   ms_in   = ms_ff | {data_byte, 24'd0};
               default: ;
            endcase
            count_in = count_inc;
            if (count_inc == bld_pkg::HDR_LEN) begin
               // length bytes are long since captured, so len_ff is final here
               if (len_ff > max_body_len) begin
                  result.valid     = 1'b1;
                  result.data.kind = bld_pkg::KIND_DROPPED;
                  phase_in = bld_pkg::PH_HUNT;
                  sync_in  = '0;
                  count_in = '0;
               end else begin
                  count_in = '0;
                  rxcrc_in = '0;
                  phase_in = (len_ff == 16'd0) ? bld_pkg::PH_CRC : bld_pkg::PH_BODY;
               end
            end
         end

         bld_pkg::PH_BODY: begin
            crc_in = crc_upd;
            result.valid           = 1'b1;
            result.data.kind       = bld_pkg::KIND_BODY;
            result.data.body_byte  = data_byte;
            result.data.body_index = count_ff;
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               count_in = '0;
               rxcrc_in = '0;
               phase_in = bld_pkg::PH_CRC;
            end
         end

         bld_pkg::PH_CRC: begin
            rxcrc_in = rxcrc_upd;
            count_in = count_inc;
            if (count_ff[1:0] == 2'd3) begin
               result.valid     = 1'b1;
               result.data.kind = (rxcrc_upd == crc_ff) ? bld_pkg::KIND_CRC_GOOD
                                                        : bld_pkg::KIND_CRC_BAD;
               phase_in = bld_pkg::PH_HUNT;
               sync_in  = '0;
               count_in = '0;
            end
         end

         default: ;
      endcase
   end

endmodule

### sv/binary_log_deframer_crc32.sv
// Top level of the binary log deframer with CRC-32 check.
// A byte accepted is held in the input register and parsed from there when the parser
// advances; its result (if any) is registered onto the rsp_ channel.
// Throughput: one byte per cycle; a result held by a stalled consumer stops the
// parser, and the input stalls while the input register is full and not advancing.
// Reset (synchronous, active high): sync hunting, both registers empty, max_body_len 4064.
module binary_log_deframer_crc32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_msg_class,
   output logic [15:0] rsp_msg_id,
   output logic [7:0]  rsp_body_byte,
   output logic [15:0] rsp_body_index,
   output logic [15:0] rsp_body_len,
   output logic [15:0] rsp_week,
   output logic [31:0] rsp_ms_of_week,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0]        max_len_ff;
   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bld_pkg::rsp_type   rsp_ff;
   bld_pkg::result_type result;
   logic               advance;
   logic               req_take;

   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= bld_pkg::MAX_BODY_RESET;
      else if (csr_wr_en) max_len_ff <= csr_wr_data;
   end

   // the parsed byte moves on unless a result is held by a stalled consumer
   assign advance     = in_valid_ff & ~(rsp_valid_ff & rsp_stall);
   assign req_stall   = in_valid_ff & ~advance;
   assign req_take    = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_data_byte;
   end

   bld_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_byte_ff),
      .max_body_len (max_len_ff),
      .result       (result)
   );

   assign rsp_valid_in = (advance & result.valid) | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance & result.valid) rsp_ff <= result.data;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_msg_class  = rsp_ff.msg_class;
   assign rsp_msg_id     = rsp_ff.msg_id;
   assign rsp_body_byte  = rsp_ff.body_byte;
   assign rsp_body_index = rsp_ff.body_index;
   assign rsp_body_len   = rsp_ff.body_len;
   assign rsp_week       = rsp_ff.week;
   assign rsp_ms_of_week = rsp_ff.ms_of_week;

endmodule

### sv/bld_checker.sv
// Port-level checks for the deframer, bound to the top level.
module bld_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [2:0]  rsp_msg_class,
   input logic [15:0] rsp_msg_id,
   input logic [7:0]  rsp_body_byte,
   input logic [15:0] rsp_body_index,
   input logic [15:0] rsp_body_len
);

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_body_index)
                                 && $stable(rsp_body_byte) && $stable(rsp_msg_id))
      else $error("rsp transaction changed while stalled");

   a_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_msg_class == bld_pkg::class_of(rsp_msg_id))
      else $error("msg_class does not match msg_id");

   a_body_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bld_pkg::KIND_BODY |-> rsp_body_index < rsp_body_len)
      else $error("body_index beyond body_len");

   a_frame_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != bld_pkg::KIND_BODY |-> rsp_body_byte == 8'd0
                                                      && rsp_body_index == 16'd0)
      else $error("frame end carries body data");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind binary_log_deframer_crc32 bld_checker u_bld_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_msg_class  (rsp_msg_class),
   .rsp_msg_id     (rsp_msg_id),
   .rsp_body_byte  (rsp_body_byte),
   .rsp_body_index (rsp_body_index),
   .rsp_body_len   (rsp_body_len)
);
